// ===== hdl/mcwd_pkg.sv =====
// Shared types and constants for the multi-channel watchdog table.
`default_nettype none
package mcwd_pkg;

  localparam int CMD_W      = 2;
  localparam int ID_W       = 22;
  localparam int TMO_W      = 24;
  localparam int STATUS_W   = 2;
  localparam int MASK_W     = 16;
  localparam int PERIOD_W   = 16;
  localparam int LIMIT_W    = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 24;

  // reset values of the configuration registers
  localparam logic                RST_MONITOR_ENABLE = 1'b0;
  localparam logic [PERIOD_W-1:0] RST_CHECK_PERIOD   = 16'd100;
  localparam logic [LIMIT_W-1:0]  RST_FATAL_LIMIT    = 24'd10000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_PERIOD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FATAL_LIMIT    = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 2'd0,
    CMD_REGISTER   = 2'd1,
    CMD_UNREGISTER = 2'd2,
    CMD_KICK       = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_BAD_TIMEOUT = 2'd1,
    ST_TABLE_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_SCAN,
    S_APPLY,
    S_RESULT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // input transfer taken this cycle
    logic step_look;  // compare one slot against the captured id
    logic step_scan;  // age-check one slot
    logic apply;      // commit register / unregister / kick
    logic load_out;   // move result into the output register
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;    // incoming item is a tick
    logic scan_req;   // incoming tick will trigger a scan
    logic last;       // walk index on the final slot
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/multi_channel_watchdog_table_unit.sv =====
// Top level of the multi-channel watchdog table.
`default_nettype none
// Watches up to ENTRIES clients. Each input transfer is a tick, register,
// unregister or kick and yields exactly one result transfer. Items are
// handled one at a time; the controller walks the slot table with a single
// compare unit, one slot per cycle. A tick without a scan goes from input
// transfer straight to the result load; a tick that scans first walks every
// slot; a register, unregister or kick walks every slot for the id lookup,
// commits in the apply state, then loads the result. A waiting result in
// the output register does not hold back the next input transfer beyond the
// point where the next result itself must be loaded. Time wraps modulo
// 2^TIME_BITS; the fatal flag is sticky until reset. The user must write
// configuration only while the block is idle; the block does not enforce it.
module multi_channel_watchdog_table_unit #(
  parameter int ENTRIES   = 16,
  parameter int TIME_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [mcwd_pkg::CMD_W-1:0]      in_cmd,
  input  wire logic [mcwd_pkg::ID_W-1:0]       in_client_id,
  input  wire logic [mcwd_pkg::TMO_W-1:0]      in_timeout_ticks,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [mcwd_pkg::STATUS_W-1:0]        out_status,
  output logic                                 out_was_present,
  output logic [mcwd_pkg::MASK_W-1:0]          out_blocked_mask,
  output logic                                 out_scan_done,
  output logic                                 out_fatal,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [mcwd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mcwd_pkg::CFG_W-1:0]      cfg_data
);
  import mcwd_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // sequencing and handshakes
  mcwd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  // slot table, time base and result register
  mcwd_dpath #(
    .ENTRIES   (ENTRIES),
    .TIME_BITS (TIME_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_cmd           (in_cmd),
    .in_client_id     (in_client_id),
    .in_timeout_ticks (in_timeout_ticks),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .ctl              (ctl),
    .sts              (sts),
    .out_status       (out_status),
    .out_was_present  (out_was_present),
    .out_blocked_mask (out_blocked_mask),
    .out_scan_done    (out_scan_done),
    .out_fatal        (out_fatal)
  );

endmodule
`default_nettype wire

// ===== hdl/mcwd_ctrl.sv =====
// Sequencing state machine and handshakes for the watchdog table.
`default_nettype none
module mcwd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire mcwd_pkg::sts_t sts,
  output mcwd_pkg::ctl_t     ctl
);
  import mcwd_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!sts.is_tick) begin
            state_nxt = S_LOOKUP;
          end else if (sts.scan_req) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_RESULT;
          end
        end
      end
      S_LOOKUP: begin
        if (sts.last) begin
          state_nxt = S_APPLY;
        end
      end
      S_SCAN: begin
        if (sts.last) begin
          state_nxt = S_RESULT;
        end
      end
      S_APPLY:  state_nxt = S_RESULT;
      S_RESULT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = (state_r != S_IDLE);
    ctl.capture   = (state_r == S_IDLE) && in_valid;
    ctl.step_look = (state_r == S_LOOKUP);
    ctl.step_scan = (state_r == S_SCAN);
    ctl.apply     = (state_r == S_APPLY);
    ctl.load_out  = (state_r == S_RESULT) && out_free;
  end

  assign out_valid_nxt = ctl.load_out ? 1'b1 : (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/mcwd_dpath.sv =====
// Slot table, time base, configuration registers and result register.
`default_nettype none
module mcwd_dpath #(
  parameter int ENTRIES   = 16,
  parameter int TIME_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [mcwd_pkg::CMD_W-1:0]      in_cmd,
  input  wire logic [mcwd_pkg::ID_W-1:0]       in_client_id,
  input  wire logic [mcwd_pkg::TMO_W-1:0]      in_timeout_ticks,
  input  wire logic                            cfg_we,
  input  wire logic [mcwd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mcwd_pkg::CFG_W-1:0]      cfg_data,
  input  wire mcwd_pkg::ctl_t                  ctl,
  output mcwd_pkg::sts_t                       sts,
  output logic [mcwd_pkg::STATUS_W-1:0]        out_status,
  output logic                                 out_was_present,
  output logic [mcwd_pkg::MASK_W-1:0]          out_blocked_mask,
  output logic                                 out_scan_done,
  output logic                                 out_fatal
);
  import mcwd_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CMP_W = (TIME_BITS > TMO_W) ? TIME_BITS : TMO_W;

  // configuration
  logic                monitor_enable_r;
  logic [PERIOD_W-1:0] check_period_r;
  logic [LIMIT_W-1:0]  fatal_limit_r;

  // slot table
  logic [ENTRIES-1:0]   valid_r;
  logic [ENTRIES-1:0]   blocked_r;
  logic [ID_W-1:0]      slot_id_r   [ENTRIES];
  logic [TMO_W-1:0]     slot_tmo_r  [ENTRIES];
  logic [TIME_BITS-1:0] slot_kick_r [ENTRIES];

  logic [TIME_BITS-1:0] now_r;
  logic [PERIOD_W-1:0]  period_r;
  logic                 fatal_r;

  // captured item and walk state
  cmd_t                 cmd_r;
  logic [ID_W-1:0]      id_r;
  logic [TMO_W-1:0]     tmo_r;
  logic [IDX_W-1:0]     idx_r;
  logic                 hit_r;
  logic [IDX_W-1:0]     hit_idx_r;
  logic [STATUS_W-1:0]  status_r;
  logic                 present_r;
  logic                 scanned_r;

  logic [PERIOD_W-1:0]  period_inc;
  logic                 period_wrap;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;
  logic [TIME_BITS-1:0] elapsed;
  logic                 ge_tmo;
  logic                 ge_limit;
  logic                 apply_reg;
  logic                 apply_unreg;
  logic                 apply_kick;
  logic [IDX_W-1:0]     kick_idx;

  assign period_inc  = period_r + PERIOD_W'(1);
  assign period_wrap = (period_inc >= check_period_r);

  assign sts.is_tick  = (cmd_t'(in_cmd) == CMD_TICK);
  assign sts.scan_req = sts.is_tick && period_wrap && monitor_enable_r;
  assign sts.last     = (idx_r == IDX_W'(ENTRIES - 1));

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // age of the slot under the walk index, modulo the time width
  assign elapsed  = now_r - slot_kick_r[idx_r];
  assign ge_tmo   = CMP_W'(elapsed) >= CMP_W'(slot_tmo_r[idx_r]);
  assign ge_limit = CMP_W'(elapsed) >= CMP_W'(fatal_limit_r);

  assign apply_reg   = ctl.apply && (cmd_r == CMD_REGISTER) && (tmo_r != '0)
                       && !hit_r && free_found;
  assign apply_unreg = ctl.apply && (cmd_r == CMD_UNREGISTER) && hit_r;
  assign apply_kick  = ctl.apply && (cmd_r == CMD_KICK) && hit_r;
  assign kick_idx    = apply_reg ? free_idx : hit_idx_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      monitor_enable_r <= RST_MONITOR_ENABLE;
      check_period_r   <= RST_CHECK_PERIOD;
      fatal_limit_r    <= RST_FATAL_LIMIT;
      valid_r          <= '0;
      blocked_r        <= '0;
      now_r            <= '0;
      period_r         <= '0;
      fatal_r          <= 1'b0;
      idx_r            <= '0;
      hit_r            <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MONITOR_ENABLE: monitor_enable_r <= cfg_data[0];
          CFG_CHECK_PERIOD:   check_period_r   <= cfg_data[PERIOD_W-1:0];
          CFG_FATAL_LIMIT:    fatal_limit_r    <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end

      if (ctl.capture) begin
        idx_r <= '0;
        hit_r <= 1'b0;
        if (sts.is_tick) begin
          now_r    <= now_r + TIME_BITS'(1);
          period_r <= period_wrap ? '0 : period_inc;
        end
      end

      if (ctl.step_look || ctl.step_scan) begin
        idx_r <= sts.last ? '0 : idx_r + IDX_W'(1);
      end

      if (ctl.step_look && valid_r[idx_r] && (slot_id_r[idx_r] == id_r)) begin
        hit_r <= 1'b1;
      end

      if (ctl.step_scan && valid_r[idx_r]) begin
        blocked_r[idx_r] <= ge_tmo;
        if (ge_tmo && ge_limit) begin
          fatal_r <= 1'b1;
        end
      end

      if (apply_reg) begin
        valid_r[free_idx]   <= 1'b1;
        blocked_r[free_idx] <= 1'b0;
      end
      if (apply_unreg) begin
        valid_r[hit_idx_r]   <= 1'b0;
        blocked_r[hit_idx_r] <= 1'b0;
      end
    end
  end

  // slot contents, captured item and result
  always_ff @(posedge clk) begin
    if (apply_reg) begin
      slot_id_r[free_idx]  <= id_r;
      slot_tmo_r[free_idx] <= tmo_r;
    end
    if (apply_reg || apply_kick) begin
      slot_kick_r[kick_idx] <= now_r;
    end

    if (ctl.capture) begin
      cmd_r     <= cmd_t'(in_cmd);
      id_r      <= in_client_id;
      tmo_r     <= in_timeout_ticks;
      status_r  <= ST_OK;
      present_r <= 1'b0;
      scanned_r <= sts.scan_req;
    end

    if (ctl.step_look && valid_r[idx_r] && (slot_id_r[idx_r] == id_r)) begin
      hit_idx_r <= idx_r;
    end

    if (ctl.apply) begin
      present_r <= hit_r;
      if (cmd_r == CMD_REGISTER) begin
        if (tmo_r == '0) begin
          status_r <= ST_BAD_TIMEOUT;
        end else if (!hit_r && !free_found) begin
          status_r <= ST_TABLE_FULL;
        end
      end
    end

    if (ctl.load_out) begin
      out_status       <= status_r;
      out_was_present  <= present_r;
      out_blocked_mask <= MASK_W'(valid_r & blocked_r);
      out_scan_done    <= scanned_r;
      out_fatal        <= fatal_r;
    end
  end

endmodule
`default_nettype wire
